FILE: rtl/mss_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the MIPS subset instruction step block.
// Used by the register file, the divider and the top level.
package mss_pkg;

    localparam int unsigned ADDR_BITS_DEF = 16;

    localparam logic [15:0] ISP_RESET = 16'h9FFE;

    localparam logic [4:0] REG_ZERO = 5'd0;
    localparam logic [4:0] REG_V0   = 5'd2;
    localparam logic [4:0] REG_A1   = 5'd5;
    localparam logic [4:0] REG_A2   = 5'd6;
    localparam logic [4:0] REG_SP   = 5'd29;
    localparam logic [4:0] REG_FP   = 5'd30;
    localparam logic [4:0] REG_RA   = 5'd31;

    // Major opcodes.
    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_BLEZ    = 6'h06;
    localparam logic [5:0] OP_BGTZ    = 6'h07;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_SLTI    = 6'h0A;
    localparam logic [5:0] OP_ANDI    = 6'h0C;
    localparam logic [5:0] OP_ORI     = 6'h0D;
    localparam logic [5:0] OP_XORI    = 6'h0E;

    // Function codes under the special opcode.
    localparam logic [5:0] FN_JR      = 6'h08;
    localparam logic [5:0] FN_SYSCALL = 6'h0C;
    localparam logic [5:0] FN_MULT    = 6'h18;
    localparam logic [5:0] FN_MULTU   = 6'h19;
    localparam logic [5:0] FN_DIV     = 6'h1A;
    localparam logic [5:0] FN_DIVU    = 6'h1B;
    localparam logic [5:0] FN_ADD     = 6'h20;
    localparam logic [5:0] FN_ADDU    = 6'h21;
    localparam logic [5:0] FN_SUB     = 6'h22;
    localparam logic [5:0] FN_SUBU    = 6'h23;
    localparam logic [5:0] FN_AND     = 6'h24;
    localparam logic [5:0] FN_OR      = 6'h25;
    localparam logic [5:0] FN_XOR     = 6'h26;
    localparam logic [5:0] FN_NOR     = 6'h27;

    // Configuration register indexes.
    localparam logic CFG_RESET_PC = 1'b0;
    localparam logic CFG_ISP      = 1'b1;

    typedef struct packed {
        logic        we;
        logic [4:0]  addr;
        logic [31:0] data;
    } t_rf_wr;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_READ  = 5'b00010,
        S_READ2 = 5'b00100,
        S_EXEC  = 5'b01000,
        S_DIV   = 5'b10000
    } t_state;

endpackage

FILE: rtl/mips_subset_instruction_step.sv
`timescale 1ns / 1ps
// Top level of the MIPS subset instruction step; uses mss_pkg, mss_regfile, mss_divider.
// A request goes through S_READ and S_EXEC; SYSCALL adds S_READ2 (a third register read),
// and DIV/DIVU with a nonzero divisor adds S_DIV, set by the 32-step divider.
// One request is in flight; the next is taken only back in S_IDLE, later if a result waits.
// Synchronous active-low reset clears pc to 0, hi/lo to 0 and all registers to zero,
// except r29 and r30, which take the stack pointer value; no clearing pass is needed.
module mips_subset_instruction_step
    import mss_pkg::*;
#(
    parameter int unsigned ADDR_BITS = ADDR_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Instruction request channel.
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_instruction_word,
    // Result channel.
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_next_pc,
    output logic        o_reg_write_valid,
    output logic [4:0]  o_reg_write_index,
    output logic [31:0] o_reg_write_value,
    output logic        o_stack_write_valid,
    output logic [15:0] o_stack_write_addr,
    output logic [15:0] o_stack_write_data,
    output logic        o_syscall_seen,
    output logic [31:0] o_syscall_code,
    output logic [31:0] o_syscall_arg_addr,
    output logic [31:0] o_syscall_arg_len,
    output logic [63:0] o_hi_lo_value,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_state r_state, n_state;

    logic [ADDR_BITS-1:0] r_pc, n_pc;
    logic [15:0] r_isp;
    logic [31:0] r_hi, n_hi;
    logic [31:0] r_lo, n_lo;
    logic [31:0] r_instr;
    logic [31:0] r_a;
    logic [31:0] r_b;
    logic [31:0] r_c;
    logic        r_div_done;

    logic        r_out_valid;
    logic [15:0] r_o_pc;
    logic        r_o_wr;
    logic [4:0]  r_o_widx;
    logic [31:0] r_o_wval;
    logic        r_o_sw;
    logic [15:0] r_o_saddr;
    logic [15:0] r_o_sdata;
    logic        r_o_sys;
    logic [31:0] r_o_s2;
    logic [31:0] r_o_s5;
    logic [31:0] r_o_s6;
    logic [63:0] r_o_hilo;

    // Instruction request decode, used to pick the read addresses.
    logic [5:0]  in_op;
    logic [5:0]  in_fn;
    logic        in_sys;
    logic        in_jal;
    logic        accept;
    logic        cfg_wr;
    logic [4:0]  rd_addr_a;
    logic [4:0]  rd_addr_b;
    logic [31:0] rf_a;
    logic [31:0] rf_b;
    t_rf_wr      rf_wr;

    // Execute stage.
    logic [5:0]  op;
    logic [5:0]  fn;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [15:0] imm;
    logic [31:0] simm;
    logic [ADDR_BITS-1:0] pc_inc;
    logic [31:0] link;
    logic        wr;
    logic [4:0]  widx;
    logic [31:0] wval;
    logic        sw;
    logic        sys;
    logic        br;
    logic        is_mul;
    logic        is_div;
    logic        div_sgn;
    logic        div_start;
    logic        out_free;
    logic        commit;
    logic [65:0] prod;
    logic [31:0] pc_ext;
    logic        div_done;
    logic [31:0] div_quo;
    logic [31:0] div_rem;

    assign in_op  = i_instruction_word[31:26];
    assign in_fn  = i_instruction_word[5:0];
    assign in_sys = (in_op == OP_SPECIAL) && (in_fn == FN_SYSCALL);
    assign in_jal = (in_op == OP_JAL);

    assign o_in_stall  = (r_state != S_IDLE);
    assign accept      = i_in_valid && (r_state == S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    // Port A carries rs, r2 for SYSCALL or r29 for JAL; the second SYSCALL read
    // fetches r6 on port A while the first pair is being captured.
    always_comb begin
        if (r_state == S_READ) begin
            rd_addr_a = REG_A2;
        end else if (in_sys) begin
            rd_addr_a = REG_V0;
        end else if (in_jal) begin
            rd_addr_a = REG_SP;
        end else begin
            rd_addr_a = i_instruction_word[25:21];
        end
        rd_addr_b = in_sys ? REG_A1 : i_instruction_word[20:16];
    end

    mss_regfile u_regfile (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_addr_a (rd_addr_a),
        .i_addr_b (rd_addr_b),
        .i_wr     (rf_wr),
        .i_clr_sp (cfg_wr && (i_cfg_index == CFG_ISP)),
        .i_isp    (r_isp),
        .o_data_a (rf_a),
        .o_data_b (rf_b)
    );

    assign op     = r_instr[31:26];
    assign fn     = r_instr[5:0];
    assign rt     = r_instr[20:16];
    assign rd     = r_instr[15:11];
    assign imm    = r_instr[15:0];
    assign simm   = {{16{imm[15]}}, imm};
    assign pc_inc = r_pc + ADDR_BITS'(4);
    assign link   = 32'(pc_inc);

    assign is_mul  = (op == OP_SPECIAL) && (fn == FN_MULT || fn == FN_MULTU);
    assign is_div  = (op == OP_SPECIAL) && (fn == FN_DIV || fn == FN_DIVU);
    assign div_sgn = (fn == FN_DIV);
    // The product is formed as a 33 x 33 signed multiply so that one unit
    // serves both MULT and MULTU.
    assign prod = $signed({(fn == FN_MULT) & r_a[31], r_a})
                * $signed({(fn == FN_MULT) & r_b[31], r_b});

    // Execute: everything the instruction changes, computed from the captured
    // operands. Taken branches link r31 before the offset is applied.
    always_comb begin
        wr   = 1'b0;
        widx = REG_ZERO;
        wval = 32'd0;
        sw   = 1'b0;
        sys  = 1'b0;
        br   = 1'b0;
        n_pc = pc_inc;
        n_hi = r_hi;
        n_lo = r_lo;
        if (op == OP_SPECIAL) begin
            case (fn)
                FN_SYSCALL: begin
                    sys = 1'b1;
                end
                FN_JR: begin
                    n_pc = ADDR_BITS'(r_a);
                end
                FN_MULT, FN_MULTU: begin
                    n_hi = prod[63:32];
                    n_lo = prod[31:0];
                end
                FN_DIV, FN_DIVU: begin
                    // A zero divisor bypasses the divider entirely.
                    if (r_b == 32'd0) begin
                        n_hi = r_a;
                        n_lo = 32'hFFFF_FFFF;
                    end
                end
                FN_ADD, FN_ADDU: begin
                    wr = 1'b1; widx = rd; wval = r_a + r_b;
                end
                FN_SUB, FN_SUBU: begin
                    wr = 1'b1; widx = rd; wval = r_a - r_b;
                end
                FN_AND: begin
                    wr = 1'b1; widx = rd; wval = r_a & r_b;
                end
                FN_OR: begin
                    wr = 1'b1; widx = rd; wval = r_a | r_b;
                end
                FN_XOR: begin
                    wr = 1'b1; widx = rd; wval = r_a ^ r_b;
                end
                FN_NOR: begin
                    wr = 1'b1; widx = rd; wval = ~(r_a | r_b);
                end
                default: begin
                end
            endcase
        end else begin
            case (op)
                OP_J: begin
                    wr = 1'b1; widx = REG_RA; wval = link;
                    n_pc = ADDR_BITS'({16'h0, imm});
                end
                OP_JAL: begin
                    sw = 1'b1;
                    wr = 1'b1; widx = REG_SP; wval = r_a - 32'd4;
                    n_pc = ADDR_BITS'({16'h0, imm});
                end
                OP_BEQ: begin
                    br = (r_a == r_b);
                end
                OP_BNE: begin
                    br = (r_a != r_b);
                end
                OP_BLEZ: begin
                    br = ($signed(r_a) <= 0);
                end
                OP_BGTZ: begin
                    br = ($signed(r_a) > 0);
                end
                OP_ADDI, OP_ADDIU: begin
                    wr = 1'b1; widx = rt; wval = r_a + simm;
                end
                OP_SLTI: begin
                    wr = 1'b1; widx = rt;
                    wval = {31'd0, $signed(r_a) < $signed(simm)};
                end
                OP_ANDI: begin
                    wr = 1'b1; widx = rt; wval = r_a & {16'h0, imm};
                end
                OP_ORI: begin
                    wr = 1'b1; widx = rt; wval = r_a | {16'h0, imm};
                end
                OP_XORI: begin
                    wr = 1'b1; widx = rt; wval = r_a ^ {16'h0, imm};
                end
                default: begin
                end
            endcase
            if (br) begin
                wr = 1'b1; widx = REG_RA; wval = link;
                n_pc = ADDR_BITS'(link + {simm[29:0], 2'b00});
            end
        end
        // Writes to register zero are dropped and reported as no write.
        if (!wr || widx == REG_ZERO) begin
            wr   = 1'b0;
            widx = REG_ZERO;
            wval = 32'd0;
        end
    end

    assign out_free  = !r_out_valid || !i_out_stall;
    assign div_start = (r_state == S_EXEC) && is_div && (r_b != 32'd0) && !r_div_done;
    assign commit    = (r_state == S_EXEC) && !div_start && out_free;

    assign rf_wr.we   = commit && wr;
    assign rf_wr.addr = widx;
    assign rf_wr.data = wval;

    mss_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_signed   (div_sgn),
        .i_dividend (r_a),
        .i_divisor  (r_b),
        .o_done     (div_done),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = (r_instr[31:26] == OP_SPECIAL && r_instr[5:0] == FN_SYSCALL)
                        ? S_READ2 : S_EXEC;
            end
            S_READ2: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (div_start) begin
                    n_state = S_DIV;
                end else if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_EXEC;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pc        <= '0;
            r_isp       <= ISP_RESET;
            r_hi        <= '0;
            r_lo        <= '0;
            r_div_done  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // A new result takes the register; otherwise it drains when taken.
            r_out_valid <= commit || (r_out_valid && i_out_stall);
            if (cfg_wr) begin
                case (i_cfg_index)
                    CFG_RESET_PC: begin
                        r_pc <= ADDR_BITS'({16'h0, i_cfg_data});
                    end
                    CFG_ISP: begin
                        r_isp <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            if (r_state == S_DIV && div_done) begin
                r_hi       <= div_rem;
                r_lo       <= div_quo;
                r_div_done <= 1'b1;
            end
            if (commit) begin
                r_pc        <= n_pc;
                r_hi        <= n_hi;
                r_lo        <= n_lo;
                r_div_done  <= 1'b0;
            end
        end
    end

    assign pc_ext = 32'(n_pc);

    // Operand capture and the result register, which holds the last result
    // until the consumer takes it.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_instr <= i_instruction_word;
        end
        if (r_state == S_READ) begin
            r_a <= rf_a;
            r_b <= rf_b;
        end
        if (r_state == S_READ2) begin
            r_c <= rf_a;
        end
        if (commit) begin
            r_o_pc    <= pc_ext[15:0];
            r_o_wr    <= wr;
            r_o_widx  <= widx;
            r_o_wval  <= wval;
            r_o_sw    <= sw;
            r_o_saddr <= sw ? r_a[15:0] : 16'h0;
            r_o_sdata <= sw ? link[15:0] : 16'h0;
            r_o_sys   <= sys;
            r_o_s2    <= sys ? r_a : 32'd0;
            r_o_s5    <= sys ? r_b : 32'd0;
            r_o_s6    <= sys ? r_c : 32'd0;
            r_o_hilo  <= {n_hi, n_lo};
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_next_pc           = r_o_pc;
    assign o_reg_write_valid   = r_o_wr;
    assign o_reg_write_index   = r_o_widx;
    assign o_reg_write_value   = r_o_wval;
    assign o_stack_write_valid = r_o_sw;
    assign o_stack_write_addr  = r_o_saddr;
    assign o_stack_write_data  = r_o_sdata;
    assign o_syscall_seen      = r_o_sys;
    assign o_syscall_code      = r_o_s2;
    assign o_syscall_arg_addr  = r_o_s5;
    assign o_syscall_arg_len   = r_o_s6;
    assign o_hi_lo_value       = r_o_hilo;

endmodule

FILE: rtl/mss_regfile.sv
`timescale 1ns / 1ps
// General register file: a 32 x 32 synchronous memory with two read ports.
// Depends on mss_pkg; entries not yet written read as their reset value.
module mss_regfile
    import mss_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [4:0]  i_addr_a,
    input  logic [4:0]  i_addr_b,
    input  t_rf_wr      i_wr,
    input  logic        i_clr_sp,
    input  logic [15:0] i_isp,
    output logic [31:0] o_data_a,
    output logic [31:0] o_data_b
);

    logic [31:0] r_mem [32];
    logic [31:0] r_vld;
    logic [31:0] r_qa;
    logic [31:0] r_qb;
    logic        r_va;
    logic        r_vb;
    logic [4:0]  r_ra;
    logic [4:0]  r_rb;
    logic [31:0] def_a;
    logic [31:0] def_b;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_qa <= r_mem[i_addr_a];
        r_qb <= r_mem[i_addr_b];
        r_ra <= i_addr_a;
        r_rb <= i_addr_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_va  <= 1'b0;
            r_vb  <= 1'b0;
        end else begin
            r_va <= r_vld[i_addr_a];
            r_vb <= r_vld[i_addr_b];
            if (i_wr.we) begin
                r_vld[i_wr.addr] <= 1'b1;
            end
            // A new stack pointer value makes both frame registers fall back
            // to it.
            if (i_clr_sp) begin
                r_vld[REG_SP] <= 1'b0;
                r_vld[REG_FP] <= 1'b0;
            end
        end
    end

    assign def_a = (r_ra == REG_SP || r_ra == REG_FP) ? {16'h0, i_isp} : 32'h0;
    assign def_b = (r_rb == REG_SP || r_rb == REG_FP) ? {16'h0, i_isp} : 32'h0;
    assign o_data_a = r_va ? r_qa : def_a;
    assign o_data_b = r_vb ? r_qb : def_b;

endmodule

FILE: rtl/mss_divider.sv
`timescale 1ns / 1ps
// Iterative restoring divider, one quotient bit per cycle, signed or not.
// Depends on mss_pkg only for the common import convention.
module mss_divider
    import mss_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_signed,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quo,
    output logic [31:0] o_rem
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [31:0] r_rem;
    logic [31:0] r_quo;
    logic [31:0] r_dvs;
    logic        r_neg_q;
    logic        r_neg_r;
    logic [32:0] trial;
    logic [32:0] diff;

    assign trial = {r_rem, r_quo[31]};
    assign diff  = trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == 5'd31);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem   <= '0;
            r_quo   <= (i_signed && i_dividend[31]) ? (32'd0 - i_dividend) : i_dividend;
            r_dvs   <= (i_signed && i_divisor[31]) ? (32'd0 - i_divisor) : i_divisor;
            r_neg_q <= i_signed && (i_dividend[31] ^ i_divisor[31]);
            r_neg_r <= i_signed && i_dividend[31];
        end else if (r_busy) begin
            if (!diff[32]) begin
                r_rem <= diff[31:0];
            end else begin
                r_rem <= trial[31:0];
            end
            r_quo <= {r_quo[30:0], ~diff[32]};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_neg_q ? (32'd0 - r_quo) : r_quo;
    assign o_rem  = r_neg_r ? (32'd0 - r_rem) : r_rem;

endmodule
